// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/gce_pkg.sv =====
// Shared types and constants for the glyph color expander.
`timescale 1ns / 1ps
`default_nettype none

package gce_pkg;

  localparam int PIXELS_PER_BYTE = 8;
  localparam int LANES           = PIXELS_PER_BYTE / 2;
  localparam int LANE_IDX_W      = $clog2(LANES);
  localparam int PIX_W           = 16;
  localparam int ADDR_W          = 32;
  localparam int WORD_W          = 32;
  localparam int CNT_W           = 4;

  typedef enum logic [0:0] {
    CFG_FRAME_BASE  = 1'b0,
    CFG_LINE_STRIDE = 1'b1
  } cfg_reg_e;

  // One framebuffer write as produced by a lane.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              half;
    logic              last;
    logic              present;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== src/gce_lane.sv =====
// One pixel-pair lane: builds the word, address and flags for its pair.
`timescale 1ns / 1ps
`default_nettype none

module gce_lane (
  input  logic [gce_pkg::LANE_IDX_W-1:0] lane_i,
  input  logic [1:0]                     pair_bits_i,  // [1] earlier pixel
  input  logic [gce_pkg::CNT_W-1:0]      count_i,
  input  logic [gce_pkg::PIX_W-1:0]      fg_i,
  input  logic [gce_pkg::PIX_W-1:0]      bg_i,
  input  logic [gce_pkg::ADDR_W-1:0]     addr_i,
  output gce_pkg::lane_res_t             res_o
);
  import gce_pkg::*;

  logic [CNT_W-1:0] first_pix;
  logic [PIX_W-1:0] lo_pix;
  logic [PIX_W-1:0] hi_pix;
  logic             half;

  assign first_pix = CNT_W'({lane_i, 1'b0});
  assign half      = (count_i == first_pix + CNT_W'(1));
  assign lo_pix    = pair_bits_i[1] ? fg_i : bg_i;
  assign hi_pix    = pair_bits_i[0] ? fg_i : bg_i;

  always_comb begin
    res_o.present = (count_i > first_pix);
    res_o.half    = half;
    res_o.last    = half || (count_i == first_pix + CNT_W'(2));
    res_o.data    = half ? {{PIX_W{1'b0}}, lo_pix} : {hi_pix, lo_pix};
    res_o.addr    = addr_i + ADDR_W'({lane_i, 2'b00});
  end

endmodule

`default_nettype wire

// ===== src/gce_merge.sv =====
// Merge stage: holds the lane results of one byte and sends them in order.
`timescale 1ns / 1ps
`default_nettype none

module gce_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  gce_pkg::lane_res_t            lanes_i [gce_pkg::LANES],
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output gce_pkg::lane_res_t            out_res_o,
  output logic                          can_load_o
);
  import gce_pkg::*;

  lane_res_t             lanes_q [LANES];
  logic [LANE_IDX_W-1:0] idx_q, idx_d;
  logic                  valid_q, valid_d;
  logic                  fire;

  assign out_res_o   = lanes_q[idx_q];
  assign out_valid_o = valid_q;
  assign fire        = valid_q && out_ready_i;
  // Free once empty or while the final word of the byte leaves.
  assign can_load_o  = !valid_q || (out_ready_i && out_res_o.last);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load_i) begin
      idx_d   = '0;
      valid_d = lanes_i[0].present;
    end else if (fire) begin
      if (out_res_o.last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + LANE_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lanes_q <= lanes_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/glyph_color_expand_16bpp_core.sv =====
// Top level of the 16 bpp monochrome glyph color expander.
// Usage:
//  - Configuration: write frame_base (index 0) and line_stride (index 1) through
//    cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle. Both reset to 0.
//  - Input stream (s_axis): one word per glyph byte with its pixel count, x, y
//    and the resolved foreground and background RGB565 pixels.
//  - Output stream (m_axis): one framebuffer write per word. tdata carries the
//    byte address and the data (earlier pixel in the low half), tuser marks a
//    halfword write, tlast marks the final write of the glyph byte.
//  - Path: an accepted byte passes one register after the stride*y multiply,
//    then the merge buffer.
//  - Writes: ceil(count/2) per byte, at most 4, sent through the single output
//    port that drains one write per cycle while m_axis_tready is high. The next
//    byte loads into the merge buffer in the same cycle that the final write of
//    the current one is taken, so a saturated stream runs with no gaps.
//    A pixel count of zero produces no writes but still passes through the
//    input register; counts above eight act as eight.
//  - Backpressure: when m_axis_tready is low, the current write holds, the
//    input register fills and s_axis_tready then drops.
//  - Reset (rst_ni low, async): all in-flight words are dropped, both streams
//    go idle and the configuration registers clear.
`timescale 1ns / 1ps
`default_nettype none

module glyph_color_expand_16bpp_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // glyph_bits, pixel_count, pos_x, pos_y, fg_pixel, bg_pixel, zero pad
  input  logic [((44 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // write_address, write_data
  output logic [0:0]          m_axis_tuser,   // halfword_only
  output logic                m_axis_tlast    // last
);
  import gce_pkg::*;

  `include "assert_macros.svh"

  // Input word layout, lowest bit first.
  localparam int OFS_BITS  = 0;
  localparam int OFS_CNT   = OFS_BITS + PIXELS_PER_BYTE;
  localparam int OFS_X     = OFS_CNT + CNT_W;
  localparam int OFS_Y     = OFS_X + COORD_BITS;
  localparam int OFS_FG    = OFS_Y + COORD_BITS;
  localparam int OFS_BG    = OFS_FG + PIX_W;
  localparam int STRIDE_W  = 16;
  localparam int PROD_W    = STRIDE_W + COORD_BITS;

  // Configuration registers.
  logic [ADDR_W-1:0]   frame_base_q;
  logic [STRIDE_W-1:0] line_stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q  <= '0;
      line_stride_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_BASE:  frame_base_q  <= cfg_wdata_i;
        CFG_LINE_STRIDE: line_stride_q <= cfg_wdata_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Field unpacking.
  logic [PIXELS_PER_BYTE-1:0] in_bits;
  logic [CNT_W-1:0]           in_cnt, in_cnt_sat;
  logic [COORD_BITS-1:0]      in_x, in_y;
  logic [PIX_W-1:0]           in_fg, in_bg;

  assign in_bits    = s_axis_tdata[OFS_BITS +: PIXELS_PER_BYTE];
  assign in_cnt     = s_axis_tdata[OFS_CNT +: CNT_W];
  assign in_x       = s_axis_tdata[OFS_X +: COORD_BITS];
  assign in_y       = s_axis_tdata[OFS_Y +: COORD_BITS];
  assign in_fg      = s_axis_tdata[OFS_FG +: PIX_W];
  assign in_bg      = s_axis_tdata[OFS_BG +: PIX_W];
  assign in_cnt_sat = (in_cnt > CNT_W'(PIXELS_PER_BYTE)) ? CNT_W'(PIXELS_PER_BYTE) : in_cnt;

  // Stage 1: input register with the line offset product.
  logic                       s1_valid_q, s1_valid_d;
  logic [PIXELS_PER_BYTE-1:0] s1_bits_q;
  logic [CNT_W-1:0]           s1_cnt_q;
  logic [COORD_BITS-1:0]      s1_x_q;
  logic [PROD_W-1:0]          s1_prod_q, s1_prod_d;
  logic [PIX_W-1:0]           s1_fg_q, s1_bg_q;
  logic                       in_fire, load;

  assign s_axis_tready = !s1_valid_q || load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_prod_d     = PROD_W'(line_stride_q) * PROD_W'(in_y);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bits_q <= in_bits;
      s1_cnt_q  <= in_cnt_sat;
      s1_x_q    <= in_x;
      s1_prod_q <= s1_prod_d;
      s1_fg_q   <= in_fg;
      s1_bg_q   <= in_bg;
    end
  end

  // Start address of the byte, wraps mod 2^32.
  logic [ADDR_W-1:0] start_addr;
  assign start_addr = frame_base_q + ADDR_W'(s1_prod_q) + ADDR_W'({s1_x_q, 1'b0});

  // Lanes: lane k handles pixels 2k and 2k+1, taken from the MSB down.
  lane_res_t lane_res [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    gce_lane u_lane (
      .lane_i      (LANE_IDX_W'(k)),
      .pair_bits_i (s1_bits_q[PIXELS_PER_BYTE-1-2*k -: 2]),
      .count_i     (s1_cnt_q),
      .fg_i        (s1_fg_q),
      .bg_i        (s1_bg_q),
      .addr_i      (start_addr),
      .res_o       (lane_res[k])
    );
  end

  // Merge stage and output.
  logic      can_load;
  lane_res_t out_res;

  assign load = s1_valid_q && can_load;

  gce_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .lanes_i     (lane_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .can_load_o  (can_load)
  );

  assign m_axis_tdata = {out_res.data, out_res.addr};
  assign m_axis_tuser = out_res.half;
  assign m_axis_tlast = out_res.last;

  // Checks.
  logic              out_half, out_step;
  logic [ADDR_W-1:0] out_addr, addr_inc;

  assign out_half = m_axis_tvalid && m_axis_tuser[0];
  assign out_step = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign out_addr = m_axis_tdata[ADDR_W-1:0];
  assign addr_inc = out_addr + ADDR_W'(4);

  `ASSERT_RST(a_idle_in_reset, !rst_ni |=> !m_axis_tvalid, "output valid during reset")
  `ASSERT_CLK(a_half_is_last, out_half |-> m_axis_tlast, "halfword not last")
  `ASSERT_CLK(a_half_upper_zero, out_half |-> m_axis_tdata[63:48] == 16'h0, "halfword upper set")
  `ASSERT_CLK(a_addr_step, out_step |=> m_axis_tvalid && out_addr == $past(addr_inc), "bad step")

endmodule

`default_nettype wire

// ===== dv/glyph_color_expand_16bpp_core_tb.sv =====
// Self-checking testbench for the 16 bpp glyph color expander core.
`timescale 1ns / 1ps

module glyph_color_expand_16bpp_core_tb;
  import gce_pkg::*;

  // Watchdog limit: cycles with no handshake on either stream. The worst
  // legal gap is the long receiver hold below.
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Margin before a register write, as the block may still chew on a
  // zero-count byte that makes no write.
  localparam int unsigned QUIET_CYCLES = 8;

  // One glyph byte as it goes into s_axis_tdata.
  typedef struct packed {
    logic [7:0]  bits;
    logic [3:0]  pix_count;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] fg;
    logic [15:0] bg;
  } glyph_t;

  // One framebuffer write as it leaves on m_axis.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic        half;
    logic        last;
  } fb_write_t;

  // Expected framebuffer writes, computed from each accepted glyph byte.
  class fb_write_scoreboard;
    logic [31:0] frame_base;
    logic [15:0] line_stride;
    fb_write_t   writes_due[$];
    int unsigned failures;

    function new();
      frame_base  = '0;
      line_stride = '0;
      failures    = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] value);
      if (idx == CFG_FRAME_BASE) begin
        frame_base = value;
      end else begin
        line_stride = value[15:0];
      end
    endfunction

    // Expand one byte into its pixel-pair words plus an odd trailing halfword.
    function void note_glyph(glyph_t g);
      int unsigned npix;
      logic [31:0] addr;
      fb_write_t   w;
      npix = (g.pix_count > 8) ? 8 : g.pix_count;
      addr = frame_base + {16'b0, line_stride} * {20'b0, g.pos_y} + {19'b0, g.pos_x, 1'b0};
      for (int k = 0; k < npix / 2; k++) begin
        // earlier pixel (higher glyph bit) lands in the low half
        w.addr = addr;
        w.data = {g.bits[6-2*k] ? g.fg : g.bg, g.bits[7-2*k] ? g.fg : g.bg};
        w.half = 1'b0;
        w.last = (npix == 2 * k + 2);
        writes_due.push_back(w);
        addr += 32'd4;
      end
      if (npix % 2 == 1) begin
        w.addr = addr;
        w.data = {16'h0000, g.bits[8-npix] ? g.fg : g.bg};
        w.half = 1'b1;
        w.last = 1'b1;
        writes_due.push_back(w);
      end
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t want;
      if (writes_due.size() == 0) begin
        if (failures < 10)
          $display("unexpected write: addr=%h data=%h half=%b last=%b",
                   got.addr, got.data, got.half, got.last);
        failures++;
        return;
      end
      want = writes_due.pop_front();
      if (want !== got) begin
        if (failures < 10)
          $display("write mismatch: exp addr=%h data=%h half=%b last=%b, got addr=%h data=%h half=%b last=%b",
                   want.addr, want.data, want.half, want.last,
                   got.addr, got.data, got.half, got.last);
        failures++;
      end
    endfunction

    function void drain_check();
      if (writes_due.size() != 0) begin
        $display("%0d expected writes never arrived", writes_due.size());
        failures += writes_due.size();
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_idx_i     = CFG_FRAME_BASE;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // glyph_bits, pixel_count, pos_x, pos_y, fg_pixel, bg_pixel, zero pad
  logic [71:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // write_address, write_data
  logic [0:0]  m_axis_tuser;   // halfword_only
  logic        m_axis_tlast;   // last

  fb_write_scoreboard sb;
  int unsigned recv_gap_max = 16;  // receiver stall range, set per phase
  bit          hold_req     = 1'b0; // asks the receiver for one long hold
  int unsigned idle_cycles  = 0;

  glyph_color_expand_16bpp_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Offer one glyph byte after 'gap' idle cycles. Called and returns at a
  // falling edge; tvalid stays high on return so back-to-back words need no
  // second assignment in the same step.
  task automatic push_glyph(glyph_t g, int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, g.bg, g.fg, g.pos_y, g.pos_x, g.pix_count, g.bits};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_glyph(g);
    @(negedge clk_i);
  endtask

  // Wait until the block is idle, then load both registers.
  task automatic write_regs(logic [31:0] base, logic [31:0] stride);
    while (sb.writes_due.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_BASE;
    cfg_wdata_i <= base;
    sb.set_reg(CFG_FRAME_BASE, base);
    @(negedge clk_i);
    // upper stride bits are don't-care; drive them anyway
    cfg_idx_i   <= CFG_LINE_STRIDE;
    cfg_wdata_i <= stride;
    sb.set_reg(CFG_LINE_STRIDE, stride);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random glyph bytes under one register setting. Most counts are legal
  // (1..8); a few are zero or oversized to hit the no-write and saturation
  // paths.
  task automatic random_phase(logic [31:0] base, logic [31:0] stride, int unsigned n_items,
                              int unsigned send_max, int unsigned recv_max, bit squeeze);
    glyph_t      g;
    int unsigned r;
    write_regs(base, stride);
    recv_gap_max = recv_max;
    if (squeeze) hold_req = 1'b1;
    repeat (n_items) begin
      g.bits = 8'($urandom_range(255, 0));
      r = $urandom_range(99, 0);
      if (r < 6) begin
        g.pix_count = 4'd0;
      end else if (r < 14) begin
        g.pix_count = 4'($urandom_range(15, 9));
      end else begin
        g.pix_count = 4'($urandom_range(8, 1));
      end
      g.pos_x = 12'($urandom_range(4095, 0));
      g.pos_y = 12'($urandom_range(4095, 0));
      g.fg    = 16'($urandom_range(65535, 0));
      g.bg    = ($urandom_range(9, 0) == 0) ? g.fg : 16'($urandom_range(65535, 0));
      push_glyph(g, $urandom_range(send_max, 0));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Output side: random stalls per word, one long hold on request.
  initial begin : drain
    int unsigned gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // stay closed long enough for the input side to back up
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = $urandom_range(recv_gap_max, 0);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_write('{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tlast});
    end
  end

  // Watchdog: no handshake on either stream for too long ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    glyph_t     g;
    logic [7:0] pats [4];
    pats = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, reset register values: every pixel count 0..15 (zero gives
    // no write, above eight saturates), corner coordinates, black/white.
    for (int i = 0; i < 16; i++) begin
      g.bits      = pats[i % 4];
      g.pix_count = 4'(i);
      g.pos_x     = i[0] ? 12'd4095 : 12'd0;
      g.pos_y     = i[1] ? 12'd4095 : 12'd0;
      g.fg        = i[2] ? 16'hFFFF : 16'h0000;
      g.bg        = i[3] ? 16'h0000 : 16'hFFFF;
      push_glyph(g, i % 3);
    end
    s_axis_tvalid <= 1'b0;

    // Directed, top of the address space: writes wrap past 2^32.
    write_regs(32'hFFFF_FFFE, 32'h0000_FFFF);
    push_glyph('{8'h80, 4'd1, 12'd4095, 12'd4095, 16'h1234, 16'hABCD}, 0);
    push_glyph('{8'h01, 4'd8, 12'd0, 12'd4095, 16'hF800, 16'h07E0}, 0);
    push_glyph('{8'h7F, 4'd7, 12'd4095, 12'd0, 16'h001F, 16'hFFFF}, 2);
    push_glyph('{8'hFE, 4'd3, 12'd2048, 12'd1, 16'h8001, 16'h7FFE}, 0);
    s_axis_tvalid <= 1'b0;

    // Random phases: idle mix, full rate, long output hold, both extremes
    // of the registers.
    random_phase(32'hFFFF_FFFE, 32'h0000_FFFF, 55, 16, 16, 1'b0);
    random_phase($urandom, $urandom, 55, 0, 0, 1'b0);
    random_phase($urandom, $urandom, 55, 0, 16, 1'b1);
    random_phase(32'h0000_0000, 32'h0000_0000, 55, 3, 3, 1'b0);
    random_phase($urandom, $urandom, 55, 16, 0, 1'b0);
    random_phase(32'hFFFF_FFFF, 32'hFFFF_0001, 55, 16, 16, 1'b0);

    while (sb.writes_due.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    sb.drain_check();
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
